/* src/frt_pkg.sv */
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants for the fragment reassembly tracker
// Position, verdict and error codes, and default field widths.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int SEQ_BITS_DEF = 8;
	localparam int LEN_BITS_DEF = 16;
	localparam int ROOM_EXTRA   = 16;

	typedef enum logic [1:0] {
		POS_MIDDLE = 2'd0,
		POS_LAST   = 2'd1,
		POS_FIRST  = 2'd2,
		POS_WHOLE  = 2'd3
	} position_t;

	typedef enum logic [1:0] {
		V_PASS = 2'd0,
		V_HELD = 2'd1,
		V_DONE = 2'd2,
		V_DROP = 2'd3
	} verdict_t;

	typedef enum logic [2:0] {
		E_NONE      = 3'd0,
		E_FIRST_NUM = 3'd1,
		E_IDLE      = 3'd2,
		E_GAP       = 3'd3,
		E_ROOM      = 3'd4
	} error_t;

	localparam int RES_CTRL_BITS = $bits(verdict_t) + $bits(error_t) + 1;

endpackage

/* src/fragment_reassembly_tracker.sv */
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker: link-layer fragment reassembly tracker
// The result is registered and valid in the cycle after item accept while the
//   output register is free; an item taken during a result stall waits in the
//   skid slot. Throughput: one item per cycle while results are taken. During a
//   result stall one more item is taken into the skid slot, then input stalls
//   until the output moves.
// Reset: arst_n clears the packet-in-progress state and empties the buffer.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker import frt_pkg::*; #(
	parameter int SEQ_BITS = SEQ_BITS_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [1:0]          position,
	input  logic [SEQ_BITS-1:0] seq_num,
	input  logic [LEN_BITS-1:0] payload_len,
	input  logic [LEN_BITS-1:0] declared_len,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [1:0]          verdict,
	output logic [2:0]          error_code,
	output logic                abandoned,
	output logic [LEN_BITS-1:0] packet_len
);

	localparam int RES_W = RES_CTRL_BITS + LEN_BITS;

	verdict_t            res_verdict;
	error_t              res_error;
	logic                res_abandoned;
	logic [LEN_BITS-1:0] res_len;
	logic                fire;
	logic [RES_W-1:0]    res_data;
	logic [RES_W-1:0]    out_data;

	assign fire     = item_valid && item_ready;
	assign res_data = {res_verdict, res_error, res_abandoned, res_len};

	frt_core #(
		.SEQ_BITS (SEQ_BITS),
		.LEN_BITS (LEN_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.position      (position),
		.seq_num       (seq_num),
		.payload_len   (payload_len),
		.declared_len  (declared_len),
		.res_verdict   (res_verdict),
		.res_error     (res_error),
		.res_abandoned (res_abandoned),
		.res_len       (res_len)
	);

	frt_skid #(
		.WIDTH (RES_W)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.in_data   (res_data),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (out_data)
	);

	assign verdict    = out_data[RES_W-1 -: 2];
	assign error_code = out_data[RES_W-3 -: 3];
	assign abandoned  = out_data[LEN_BITS];
	assign packet_len = out_data[LEN_BITS-1:0];

endmodule

/* src/frt_core.sv */
// ----------------------------------------------------------------------------
// frt_core: reassembly state and per-item decision
// Checks one fragment descriptor against the packet in progress and
// updates the tracking state when the item is accepted.
// ----------------------------------------------------------------------------
module frt_core import frt_pkg::*; #(
	parameter int SEQ_BITS = SEQ_BITS_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [1:0]          position,
	input  logic [SEQ_BITS-1:0] seq_num,
	input  logic [LEN_BITS-1:0] payload_len,
	input  logic [LEN_BITS-1:0] declared_len,
	output verdict_t            res_verdict,
	output error_t              res_error,
	output logic                res_abandoned,
	output logic [LEN_BITS-1:0] res_len
);

	logic                in_progress_q;
	logic [SEQ_BITS-1:0] last_seq_q;
	logic [LEN_BITS:0]   assembled_q;
	logic [LEN_BITS:0]   room_q;

	logic                in_progress_d;
	logic [SEQ_BITS-1:0] last_seq_d;
	logic [LEN_BITS:0]   assembled_d;
	logic [LEN_BITS:0]   room_d;

	position_t           pos;
	logic [LEN_BITS:0]   plen_x;
	logic [LEN_BITS:0]   dsum;
	logic [LEN_BITS:0]   room_first;
	logic [SEQ_BITS:0]   seq_expect;
	logic                gap;
	logic                no_room;
	logic [LEN_BITS:0]   asm_new;

	assign pos        = position_t'(position);
	assign plen_x     = {1'b0, payload_len};
	assign dsum       = {1'b0, declared_len} + (LEN_BITS+1)'(ROOM_EXTRA);
	assign room_first = (dsum >= plen_x) ? (dsum - plen_x) : '0;
	// next number is computed one bit wider so a maxed counter never matches
	assign seq_expect = {1'b0, last_seq_q} + (SEQ_BITS+1)'(1);
	assign gap        = {1'b0, seq_num} != seq_expect;
	assign no_room    = room_q < plen_x;
	assign asm_new    = assembled_q + plen_x;

	always_comb begin
		in_progress_d = in_progress_q;
		last_seq_d    = last_seq_q;
		assembled_d   = assembled_q;
		room_d        = room_q;
		res_verdict   = V_DROP;
		res_error     = E_NONE;
		res_abandoned = 1'b0;
		res_len       = '0;
		case (pos)
			POS_WHOLE: begin
				res_verdict = V_PASS;
				res_len     = payload_len;
			end
			POS_FIRST: begin
				res_abandoned = in_progress_q;
				if (seq_num != '0) begin
					in_progress_d = 1'b0;
					res_error     = E_FIRST_NUM;
				end else begin
					in_progress_d = 1'b1;
					last_seq_d    = '0;
					assembled_d   = plen_x;
					room_d        = room_first;
					res_verdict   = V_HELD;
				end
			end
			POS_MIDDLE, POS_LAST: begin
				if (!in_progress_q) begin
					res_error = E_IDLE;
				end else if (gap) begin
					in_progress_d = 1'b0;
					res_error     = E_GAP;
					res_abandoned = 1'b1;
				end else if (no_room) begin
					in_progress_d = 1'b0;
					res_error     = E_ROOM;
					res_abandoned = 1'b1;
				end else begin
					assembled_d = asm_new;
					room_d      = room_q - plen_x;
					if (pos == POS_LAST) begin
						in_progress_d = 1'b0;
						res_verdict   = V_DONE;
						// saturate the reported length
						res_len       = asm_new[LEN_BITS] ? '1 : asm_new[LEN_BITS-1:0];
					end else begin
						last_seq_d  = seq_num;
						res_verdict = V_HELD;
					end
				end
			end
			default: begin
				res_verdict = V_DROP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_progress_q <= 1'b0;
			last_seq_q    <= '0;
			assembled_q   <= '0;
			room_q        <= '0;
		end else if (fire) begin
			in_progress_q <= in_progress_d;
			last_seq_q    <= last_seq_d;
			assembled_q   <= assembled_d;
			room_q        <= room_d;
		end
	end

endmodule

/* src/frt_skid.sv */
// ----------------------------------------------------------------------------
// frt_skid: two-entry result buffer
// Output register plus a skid slot so an item is taken while a result waits.
// ----------------------------------------------------------------------------
module frt_skid import frt_pkg::*; #(
	parameter int WIDTH = RES_CTRL_BITS + LEN_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             main_valid_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] main_q;
	logic [WIDTH-1:0] skid_q;
	logic             in_fire;
	logic             main_free;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign main_free = !main_valid_q || out_ready;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (in_fire) begin
				main_q <= in_data;
			end
		end else if (in_fire) begin
			// hold the new item behind the stalled result
			skid_q <= in_data;
		end
	end

endmodule
